// File: hw/rtl/sharpen_3x3_convolution_unit_defines.svh
// Assertion macros shared by the sharpening unit.
`ifndef SHARPEN_3X3_CONVOLUTION_UNIT_DEFINES_SVH
`define SHARPEN_3X3_CONVOLUTION_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and off while arst_n is low.
`define SHP3_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, sampled on clk and off while arst_n is low.
`define SHP3_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: hw/rtl/shp3_pkg.sv
// Shared constants and types of the 3x3 sharpening unit.
package shp3_pkg;

	// Pixel and field widths.
	localparam int CH_W      = 8;
	localparam int PIX_W     = 3 * CH_W;
	localparam int POS_W     = 11;
	localparam int ROW_W     = 11;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] IDX_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] IDX_HEIGHT = 2'd1;

	// Frame size limits and reset values.
	localparam int MIN_DIM       = 3;
	localparam int MAX_HEIGHT    = 2048;
	localparam int WIDTH_RESET   = 640;
	localparam int HEIGHT_RESET  = 480;
	localparam int DEF_MAX_WIDTH = 2048;

	// Queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Packed pixel: blue in the low byte, red in the high byte.
	typedef logic [PIX_W-1:0] pix_t;

	// 3x3 window, indexed [row][column], row 0 on top.
	typedef pix_t [2:0][2:0] win_t;

	typedef struct packed {
		win_t             win;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             frame_end;
	} q_entry_t;

	typedef struct packed {
		logic              nonempty;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

	typedef struct packed {
		logic                 valid;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_W-1:0]     data;
	} cfg_wr_t;

endpackage

// File: hw/rtl/shp3_ram.sv
// Generic single-write, single-read RAM with registered read data.
module shp3_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/shp3_front.sv
// Front end: position tracking, line buffers and the 3x3 window.
module shp3_front
	import shp3_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [CH_W-1:0] in_blue,
	input  logic [CH_W-1:0] in_green,
	input  logic [CH_W-1:0] in_red,
	input  logic            frame_start,
	input  cfg_wr_t         cfg,
	input  q_stat_t         qstat,
	output logic            q_push,
	output q_entry_t        q_entry
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = AW + 1;
	localparam logic [WW-1:0] W_RST =
		WW'((WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET);
	localparam logic [CFG_W-1:0] H_RST =
		CFG_W'((HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET);

	// Saturate a written frame dimension into MIN_DIM..hi.
	function automatic logic [31:0] clamp_dim(input logic [CFG_W-1:0] v,
			input logic [31:0] hi);
		logic [31:0] v32;
		begin
			v32 = 32'(v);
			if (v32 < 32'(MIN_DIM)) begin
				clamp_dim = 32'(MIN_DIM);
			end else if (v32 > hi) begin
				clamp_dim = hi;
			end else begin
				clamp_dim = v32;
			end
		end
	endfunction

	logic [WW-1:0]    width_q;
	logic [CFG_W-1:0] height_q;
	logic [AW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	logic             accept;
	logic [AW-1:0]    c_cur;
	logic [ROW_W-1:0] r_cur;
	logic [WW-1:0]    col_inc;
	logic [CFG_W-1:0] row_inc;
	logic             col_wrap;
	logic             row_wrap;
	pix_t             px;

	logic             valid_s1;
	pix_t             px_s1;
	logic             par_s1;
	logic             emit_s1;
	logic [POS_W-1:0] row_s1;
	logic [POS_W-1:0] col_s1;
	logic             fend_s1;

	pix_t rd_even;
	pix_t rd_odd;
	pix_t above2;
	pix_t above1;
	win_t win_q;
	win_t win_next;

	logic [QCNT_W:0] pending;

	// Hold off the input while the queue could not take every item in flight.
	assign pending  = (QCNT_W + 1)'(qstat.count) + (QCNT_W + 1)'(valid_s1 & emit_s1);
	assign in_stall = pending >= (QCNT_W + 1)'(QUEUE_DEPTH);
	assign accept   = in_valid & ~in_stall;

	// Position of the incoming pixel and the step to the next one.
	assign px       = {in_red, in_green, in_blue};
	assign c_cur    = frame_start ? '0 : col_q;
	assign r_cur    = frame_start ? '0 : row_q;
	assign col_inc  = WW'(c_cur) + WW'(1);
	assign row_inc  = CFG_W'(r_cur) + CFG_W'(1);
	assign col_wrap = col_inc >= width_q;
	assign row_wrap = row_inc >= height_q;

	// Configuration registers and position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= W_RST;
			height_q <= H_RST;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			priority if (cfg.valid && cfg.index == IDX_WIDTH) begin
				width_q <= WW'(clamp_dim(cfg.data, 32'(MAX_WIDTH)));
				col_q   <= '0;
				row_q   <= '0;
			end else if (cfg.valid && cfg.index == IDX_HEIGHT) begin
				height_q <= CFG_W'(clamp_dim(cfg.data, 32'(MAX_HEIGHT)));
				col_q    <= '0;
				row_q    <= '0;
			end else if (accept) begin
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : row_inc[ROW_W-1:0];
				end else begin
					col_q <= col_inc[AW-1:0];
					row_q <= r_cur;
				end
			end
		end
	end

	// Line buffers: even rows in one bank, odd rows in the other.
	shp3_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_bank_even (
		.clk  (clk),
		.we   (accept & ~r_cur[0]),
		.waddr(c_cur),
		.wdata(px),
		.re   (accept),
		.raddr(c_cur),
		.rdata(rd_even)
	);

	shp3_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_bank_odd (
		.clk  (clk),
		.we   (accept & r_cur[0]),
		.waddr(c_cur),
		.wdata(px),
		.re   (accept),
		.raddr(c_cur),
		.rdata(rd_odd)
	);

	// Stage 1 control, waiting for the line buffer read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Stage 1 payload and classification of the pixel.
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= px;
			par_s1  <= r_cur[0];
			emit_s1 <= (r_cur >= ROW_W'(2)) && (c_cur >= AW'(2));
			row_s1  <= POS_W'(r_cur - ROW_W'(1));
			col_s1  <= POS_W'(c_cur - AW'(1));
			fend_s1 <= col_wrap & row_wrap;
		end
	end

	// The bank of the current row parity holds the row two above.
	assign above2 = par_s1 ? rd_odd : rd_even;
	assign above1 = par_s1 ? rd_even : rd_odd;

	// Shift the window left and bring in the new right-hand column.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_next[k][0] = win_q[k][1];
			win_next[k][1] = win_q[k][2];
		end
		win_next[0][2] = above2;
		win_next[1][2] = above1;
		win_next[2][2] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (valid_s1) begin
			win_q <= win_next;
		end
	end

	// Interior pixels go to the queue with their window.
	assign q_push            = valid_s1 & emit_s1;
	assign q_entry.win       = win_next;
	assign q_entry.row       = row_s1;
	assign q_entry.col       = col_s1;
	assign q_entry.frame_end = fend_s1;

endmodule

// File: hw/rtl/shp3_queue.sv
// Small queue of windows between the front end and the back end.
module shp3_queue
	import shp3_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	input  logic     pop,
	output q_entry_t head,
	output q_stat_t  qstat
);

	q_entry_t          entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Pointer step with wrap at the queue depth.
	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		begin
			if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
				ptr_next = '0;
			end else begin
				ptr_next = p + QPTR_W'(1);
			end
		end
	endfunction

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head           = entries_q[rd_ptr_q];
	assign qstat.count    = count_q;
	assign qstat.nonempty = count_q != '0;

endmodule

// File: hw/rtl/shp3_back.sv
// Back end: kernel sums, rounding, saturation and the output register.
module shp3_back
	import shp3_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  q_entry_t         head,
	input  q_stat_t          qstat,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [CH_W-1:0]  out_blue,
	output logic [CH_W-1:0]  out_green,
	output logic [CH_W-1:0]  out_red,
	output logic [POS_W-1:0] out_row,
	output logic [POS_W-1:0] out_col,
	output logic             frame_end
);

	// Kernel sum of one channel, in -3060..3060.
	function automatic logic signed [13:0] conv_sum(input win_t w, input logic [1:0] ch);
		logic [CH_W-1:0] ctr;
		logic [9:0]      edges;
		logic [9:0]      corners;
		logic [11:0]     ctr12;
		begin
			ctr     = w[1][1][8*ch +: CH_W];
			edges   = 10'(w[0][1][8*ch +: CH_W]) + 10'(w[1][0][8*ch +: CH_W])
				+ 10'(w[1][2][8*ch +: CH_W]) + 10'(w[2][1][8*ch +: CH_W]);
			corners = 10'(w[0][0][8*ch +: CH_W]) + 10'(w[0][2][8*ch +: CH_W])
				+ 10'(w[2][0][8*ch +: CH_W]) + 10'(w[2][2][8*ch +: CH_W]);
			ctr12   = {1'b0, ctr, 3'b000} + {2'b00, ctr, 2'b00};
			conv_sum = $signed({2'b00, ctr12}) - $signed({3'b000, edges, 1'b0})
				- $signed({4'b0000, corners});
		end
	endfunction

	// Quarter with round half to even, clamp, add the centre, clamp again.
	function automatic logic [CH_W-1:0] finish(input logic signed [13:0] s,
			input logic [CH_W-1:0] ctr);
		logic [11:0] q;
		logic [8:0]  t;
		begin
			if (s <= 14'sd0) begin
				q = '0;
			end else begin
				q = s[13:2];
				if (s[1:0] == 2'd3 || (s[1:0] == 2'd2 && q[0])) begin
					q = q + 12'd1;
				end
				if (q > 12'd255) begin
					q = 12'd255;
				end
			end
			t = {1'b0, q[7:0]} + {1'b0, ctr};
			finish = t[8] ? 8'hFF : t[7:0];
		end
	endfunction

	logic                    valid_s2;
	logic signed [2:0][13:0] sum_s2;
	pix_t                    ctr_s2;
	logic [POS_W-1:0]        row_s2;
	logic [POS_W-1:0]        col_s2;
	logic                    fend_s2;

	logic             valid_s3;
	logic [CH_W-1:0]  blue_s3;
	logic [CH_W-1:0]  green_s3;
	logic [CH_W-1:0]  red_s3;
	logic [POS_W-1:0] row_s3;
	logic [POS_W-1:0] col_s3;
	logic             fend_s3;

	logic ready_s3;
	logic ready_s2;

	// Each stage moves on when the one after it has room.
	assign ready_s3 = ~valid_s3 | ~out_stall;
	assign ready_s2 = ~valid_s2 | ready_s3;
	assign pop      = qstat.nonempty & ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= pop;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Stage 2: kernel sums of the three channels.
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int ch = 0; ch < 3; ch++) begin
				sum_s2[ch] <= conv_sum(head.win, 2'(ch));
			end
			ctr_s2  <= head.win[1][1];
			row_s2  <= head.row;
			col_s2  <= head.col;
			fend_s2 <= head.frame_end;
		end
	end

	// Stage 3: output register, held while the transfer is stalled.
	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			blue_s3  <= finish(sum_s2[0], ctr_s2[CH_W-1:0]);
			green_s3 <= finish(sum_s2[1], ctr_s2[2*CH_W-1:CH_W]);
			red_s3   <= finish(sum_s2[2], ctr_s2[3*CH_W-1:2*CH_W]);
			row_s3   <= row_s2;
			col_s3   <= col_s2;
			fend_s3  <= fend_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_blue  = blue_s3;
	assign out_green = green_s3;
	assign out_red   = red_s3;
	assign out_row   = row_s3;
	assign out_col   = col_s3;
	assign frame_end = fend_s3;

endmodule

// File: hw/rtl/sharpen_3x3_convolution_unit.sv
// A result passes stage 1, the window queue, stage 2 and the output register after the
// transfer of the pixel one row below and one column right of its centre pixel.
// Throughput: one pixel per cycle while in_stall is low, set by the single read of each line buffer bank.
// The input stalls only when the four-entry window queue could overflow.
// Reset (arst_n low) clears position, window, queue and pipeline; width 640, height 480.
// The line buffers are not cleared; no result uses an entry before it is written.
`include "sharpen_3x3_convolution_unit_defines.svh"

module sharpen_3x3_convolution_unit
	import shp3_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CH_W-1:0]      in_blue,
	input  logic [CH_W-1:0]      in_green,
	input  logic [CH_W-1:0]      in_red,
	input  logic                 frame_start,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CH_W-1:0]      out_blue,
	output logic [CH_W-1:0]      out_green,
	output logic [CH_W-1:0]      out_red,
	output logic [POS_W-1:0]     out_row,
	output logic [POS_W-1:0]     out_col,
	output logic                 frame_end,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_wr_t  cfg;
	q_stat_t  qstat;
	q_entry_t q_entry;
	q_entry_t q_head;
	logic     q_push;
	logic     q_pop;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	shp3_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_blue    (in_blue),
		.in_green   (in_green),
		.in_red     (in_red),
		.frame_start(frame_start),
		.cfg        (cfg),
		.qstat      (qstat),
		.q_push     (q_push),
		.q_entry    (q_entry)
	);

	shp3_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_entry(q_entry),
		.pop       (q_pop),
		.head      (q_head),
		.qstat     (qstat)
	);

	shp3_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.qstat    (qstat),
		.pop      (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_blue (out_blue),
		.out_green(out_green),
		.out_red  (out_red),
		.out_row  (out_row),
		.out_col  (out_col),
		.frame_end(frame_end)
	);

	// The front end never pushes into a full queue.
	`SHP3_ASSERT_NOW(a_push_room, q_push, qstat.count < QCNT_W'(QUEUE_DEPTH), "push into full queue")
	// The back end only pops a queue that holds an entry.
	`SHP3_ASSERT_NOW(a_pop_nonempty, q_pop, qstat.nonempty, "pop from empty queue")
	// An empty queue never holds off the input.
	`SHP3_ASSERT_NOW(a_empty_no_stall, !qstat.nonempty, !in_stall, "stall with empty queue")
	// A push without a pop leaves an entry in the queue.
	`SHP3_ASSERT_NEXT(a_push_fills, q_push && !q_pop, qstat.nonempty, "pushed entry lost")

endmodule

// File: tb/sharpen_checker.sv
// Checker that predicts and compares the sharpened pixels of the 3x3 unit.
module sharpen_checker
	import shp3_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [CH_W-1:0]      in_blue,
	input  logic [CH_W-1:0]      in_green,
	input  logic [CH_W-1:0]      in_red,
	input  logic                 frame_start,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [CH_W-1:0]      out_blue,
	input  logic [CH_W-1:0]      out_green,
	input  logic [CH_W-1:0]      out_red,
	input  logic [POS_W-1:0]     out_row,
	input  logic [POS_W-1:0]     out_col,
	input  logic                 frame_end,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   pending
);

	localparam int LINE_AW = $clog2(DEF_MAX_WIDTH);

	typedef struct packed {
		logic [CH_W-1:0]  blue;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  red;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             frame_last;
	} sharp_px_t;

	// Mirror of the unit: two line rows, the 3x3 window, position and frame size.
	bit [PIX_W-1:0]   line_mem [2][DEF_MAX_WIDTH];
	bit [PIX_W-1:0]   window [3][3];
	int unsigned      row_pos;
	int unsigned      col_pos;
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	sharp_px_t        expected_pixels [$];
	int               errors;

	assign fail_count = errors;

	// The frame size in use saturates into the supported range.
	function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
		if (v < MIN_DIM)
			return MIN_DIM;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Kernel -1 -2 -1 / -2 12 -2 / -1 -2 -1 on one channel, quarter with ties to even,
	// clamp, then add back the centre pixel with saturation.
	function automatic logic [CH_W-1:0] sharpen_channel(int sh);
		int          v [3][3];
		int          s;
		int unsigned q;
		int unsigned t;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				v[i][j] = int'(window[i][j][sh +: CH_W]);
		s = 12 * v[1][1] - 2 * (v[0][1] + v[1][0] + v[1][2] + v[2][1])
			- (v[0][0] + v[0][2] + v[2][0] + v[2][2]);
		if (s <= 0) begin
			q = 0;
		end else begin
			q = s >> 2;
			if ((s & 3) == 3 || ((s & 3) == 2 && q[0]))
				q++;
			if (q > 255)
				q = 255;
		end
		t = q + v[1][1];
		return (t > 255) ? 8'hFF : CH_W'(t);
	endfunction

	// One pixel transfer: update line rows and window, queue a result for interior pixels.
	task automatic accept_pixel(input bit [PIX_W-1:0] px, input bit start);
		int unsigned    w;
		int unsigned    h;
		int unsigned    r;
		int unsigned    c;
		bit [PIX_W-1:0] above2;
		bit [PIX_W-1:0] above1;
		sharp_px_t      res;
		w = clamp_dim(32'(width_reg), DEF_MAX_WIDTH);
		h = clamp_dim(32'(height_reg), MAX_HEIGHT);
		if (start) begin
			row_pos = 0;
			col_pos = 0;
		end
		if (col_pos >= w)
			col_pos = 0;
		if (row_pos >= h)
			row_pos = 0;
		r = row_pos;
		c = col_pos;

		above2 = line_mem[r[0]][c[LINE_AW-1:0]];
		above1 = line_mem[~r[0]][c[LINE_AW-1:0]];
		line_mem[r[0]][c[LINE_AW-1:0]] = px;
		for (int k = 0; k < 3; k++) begin
			window[k][0] = window[k][1];
			window[k][1] = window[k][2];
		end
		window[0][2] = above2;
		window[1][2] = above1;
		window[2][2] = px;

		if (r >= 2 && c >= 2) begin
			res.blue       = sharpen_channel(0);
			res.green      = sharpen_channel(CH_W);
			res.red        = sharpen_channel(2 * CH_W);
			res.row        = POS_W'(r - 1);
			res.col        = POS_W'(c - 1);
			res.frame_last = (r == h - 1) && (c == w - 1);
			expected_pixels.push_back(res);
		end

		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h)
				row_pos = 0;
		end
	endtask

	task automatic check_field(input string name, input logic [POS_W-1:0] want,
			input logic [POS_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endtask

	// On every edge, follow writes and input transfers and check all fields of each result.
	always @(posedge clk or negedge arst_n) begin
		sharp_px_t want;
		if (!arst_n) begin
			width_reg  = CFG_W'(WIDTH_RESET);
			height_reg = CFG_W'(HEIGHT_RESET);
			row_pos    = 0;
			col_pos    = 0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					window[i][j] = '0;
			expected_pixels.delete();
			pending <= 0;
		end else begin
			// A register write restarts the frame; other indexes are ignored.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					IDX_WIDTH: begin
						width_reg = cfg_data;
						row_pos   = 0;
						col_pos   = 0;
					end
					IDX_HEIGHT: begin
						height_reg = cfg_data;
						row_pos    = 0;
						col_pos    = 0;
					end
					default: ;
				endcase
			end

			if (in_valid && !in_stall)
				accept_pixel({in_red, in_green, in_blue}, frame_start);

			// Each result transfer is compared with the oldest prediction.
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$error("result at row %0d col %0d with none expected", out_row, out_col);
					errors++;
				end else begin
					want = expected_pixels.pop_front();
					check_field("out_blue", POS_W'(want.blue), POS_W'(out_blue));
					check_field("out_green", POS_W'(want.green), POS_W'(out_green));
					check_field("out_red", POS_W'(want.red), POS_W'(out_red));
					check_field("out_row", want.row, out_row);
					check_field("out_col", want.col, out_col);
					check_field("frame_end", POS_W'(want.frame_last), POS_W'(frame_end));
				end
			end
			pending <= expected_pixels.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// Top of the sharpening unit testbench: clock, reset, stimulus and verdict.
module tb_top;
	import shp3_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 330;
	localparam int WIDE_ITEMS    = 24;
	localparam int TALL_ITEMS    = 60;

	// Register indexes that the unit does not decode.
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 2'd3;

	typedef enum int {STYLE_NOISE, STYLE_SMOOTH, STYLE_EXTREME, STYLE_SPARSE} pix_style_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [CH_W-1:0]      in_blue;
	logic [CH_W-1:0]      in_green;
	logic [CH_W-1:0]      in_red;
	logic                 frame_start;
	logic                 out_valid;
	logic                 out_stall;
	logic [CH_W-1:0]      out_blue;
	logic [CH_W-1:0]      out_green;
	logic [CH_W-1:0]      out_red;
	logic [POS_W-1:0]     out_row;
	logic [POS_W-1:0]     out_col;
	logic                 frame_end;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int fail_count;
	int pending;
	int cycle_count;
	int random_items;
	int frame_w;
	int frame_h;
	bit send_quiet;
	bit recv_quiet;

	sharpen_3x3_convolution_unit u_dut (.*);

	sharpen_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop if the run hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int usable_dim(int v, int hi);
		return (v < MIN_DIM) ? MIN_DIM : (v > hi) ? hi : v;
	endfunction

	function automatic bit [PIX_W-1:0] make_pixel(pix_style_t style, bit [CH_W-1:0] base);
		bit [PIX_W-1:0] px;
		px = PIX_W'($urandom());
		for (int k = 0; k < 3; k++) begin
			case (style)
				STYLE_SMOOTH:  px[k*CH_W +: CH_W] = base + CH_W'($urandom_range(0, 7));
				STYLE_EXTREME: px[k*CH_W +: CH_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				STYLE_SPARSE:
					if ($urandom_range(0, 5) != 0)
						px[k*CH_W +: CH_W] = '0;
				default: ;
			endcase
		end
		return px;
	endfunction

	// Present one pixel after a random gap and hold it until its transfer.
	task automatic send_pixel(input bit [PIX_W-1:0] px, input bit start);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid                     <= 1'b1;
		{in_red, in_green, in_blue}  <= px;
		frame_start                  <= start;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	// Lower valid, let every predicted result drain, then let the pipeline settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (index == IDX_WIDTH)
			frame_w = usable_dim(int'(data), DEF_MAX_WIDTH);
		else if (index == IDX_HEIGHT)
			frame_h = usable_dim(int'(data), MAX_HEIGHT);
	endtask

	// A frame is mostly well formed; otherwise it is cut short or overruns, with stray
	// frame starts scattered through it.
	task automatic send_frame(input bit whole);
		bit         well;
		int         count;
		pix_style_t style;
		bit [7:0]   base;
		well       = whole || ($urandom_range(0, 4) != 0);
		count      = well ? frame_w * frame_h : $urandom_range(1, frame_w * frame_h + frame_w);
		style      = pix_style_t'($urandom_range(0, 3));
		base       = CH_W'($urandom());
		send_quiet = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < count; i++)
			send_pixel(make_pixel(style, base), well ? (i == 0) : ($urandom_range(0, 15) == 0));
		random_items += count;
	endtask

	// Result side: a random stall before each transfer, with quiet stretches.
	initial begin
		int n;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				recv_quiet = !recv_quiet;
			n = recv_quiet ? 0 : $urandom_range(0, 8);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// Stimulus and verdict.
	initial begin
		bit [CH_W-1:0] nb;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		in_blue     <= '0;
		in_green    <= '0;
		in_red      <= '0;
		frame_start <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= IDX_WIDTH;
		cfg_data    <= '0;
		frame_w     = WIDTH_RESET;
		frame_h     = HEIGHT_RESET;
		send_quiet  = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A few pixels at the reset frame size, which yield nothing.
		for (int i = 0; i < 5; i++)
			send_pixel(PIX_W'($urandom()), i == 0);
		wait_idle();

		// Sizes below the range saturate to the smallest frame.
		write_reg(IDX_WIDTH, 12'd0);
		write_reg(IDX_HEIGHT, 12'd2);

		// Full-scale edges: blue and green see a dark centre in a white ring, red the opposite.
		for (int i = 0; i < 9; i++) begin
			nb = (i == 4) ? 8'h00 : 8'hFF;
			send_pixel({~nb, nb, nb}, i == 0);
		end

		// Overrun into the next frame without a frame start. Small values exercise the
		// rounding: blue a plain quarter, green a tie onto an odd quotient, red a tie
		// onto an even one. Ignored register writes land mid-frame and must not restart it.
		for (int i = 0; i < 9; i++) begin
			if (i == 4) begin
				wait_idle();
				write_reg(IDX_SPARE_LO, 12'hFFF);
				write_reg(IDX_SPARE_HI, 12'h000);
			end
			send_pixel({(i == 4) ? 8'd2 : (i == 0) ? 8'd6 : 8'd0,
				(i == 4 || i == 0) ? 8'd2 : 8'd0,
				(i == 4) ? 8'd1 : 8'd0}, 1'b0);
		end
		random_items = 0;

		// Random phases over small frame sizes.
		while (random_items < RANDOM_ITEMS) begin
			wait_idle();
			case ($urandom_range(0, 5))
				0: begin
					write_reg(IDX_WIDTH, CFG_W'($urandom_range(3, 9)));
					write_reg(IDX_HEIGHT, CFG_W'($urandom_range(3, 6)));
				end
				1: write_reg(IDX_WIDTH, CFG_W'($urandom_range(3, 9)));
				2: write_reg(IDX_HEIGHT, CFG_W'($urandom_range(3, 6)));
				3: begin
					write_reg(IDX_WIDTH, CFG_W'($urandom_range(0, 2)));
					write_reg(IDX_HEIGHT, CFG_W'($urandom_range(0, 2)));
				end
				4: write_reg($urandom_range(0, 1) ? IDX_SPARE_LO : IDX_SPARE_HI,
					CFG_W'($urandom()));
				default: ;
			endcase
			repeat ($urandom_range(1, 3))
				send_frame(1'b0);
		end

		// Width register above the range: the start of a row that is too long to finish,
		// so nothing may come out.
		wait_idle();
		write_reg(IDX_WIDTH, 12'hFFF);
		write_reg(IDX_HEIGHT, 12'd3);
		for (int i = 0; i < WIDE_ITEMS; i++)
			send_pixel(make_pixel(STYLE_NOISE, 8'h00), i == 0);

		// Height register at the top of the range: a narrow strip of the first rows.
		wait_idle();
		write_reg(IDX_WIDTH, 12'd3);
		write_reg(IDX_HEIGHT, 12'd2048);
		for (int i = 0; i < TALL_ITEMS; i++)
			send_pixel(make_pixel(STYLE_NOISE, 8'h00), i == 0);

		wait_idle();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
